// ===== src/mf3_pkg.sv =====
package mf3_pkg;

	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int PIXEL_BITS_DEF = 8;

	// fixed field widths on the ports
	localparam int DATA_W = 8;
	localparam int CFG_W  = 12;
	localparam int USER_W = 2;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd2048;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd2048;

	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} mf3_reg_t;

	// per-beat control decided at the input, carried down the pipe
	typedef struct packed {
		logic drain;     // row counter at or past height: bottom row replicate
		logic last;      // last column of the row
		logic row_ge1;   // results are due for this row
		logic row_le1;   // top edge: row above is the middle row
		logic col_zero;  // first column: window is reloaded
	} mf3_ctl_t;

endpackage

// ===== src/mf3_line_buf.sv =====
module mf3_line_buf #(
	parameter int DEPTH = 2048,
	parameter int DW    = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DW-1:0]            rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	// write-first: a read hitting the address written on the same edge sees the new word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= (we && (waddr == raddr)) ? wdata : mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/mf3_window.sv =====
module mf3_window #(
	parameter int PIXEL_BITS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  mf3_pkg::mf3_ctl_t                ctl,
	input  logic [PIXEL_BITS-1:0]            pix,
	input  logic [PIXEL_BITS-1:0]            rd_upper,
	input  logic [PIXEL_BITS-1:0]            rd_mid,
	output logic [2:0][2:0][PIXEL_BITS-1:0]  win
);

	import mf3_pkg::*;

	// win[column][row], column 0 is leftmost, row 0 is top
	logic [2:0][2:0][PIXEL_BITS-1:0] win_q;
	logic [2:0][PIXEL_BITS-1:0]      col_new;

	always_comb begin
		col_new[0] = ctl.row_le1 ? rd_mid : rd_upper;
		col_new[1] = rd_mid;
		col_new[2] = ctl.drain ? rd_mid : pix;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (en) begin
			if (ctl.col_zero) begin
				win_q <= {col_new, col_new, col_new};
			end else begin
				win_q <= {col_new, win_q[2], win_q[1]};
			end
		end
	end

	assign win = win_q;

endmodule

// ===== src/mf3_median_out.sv =====
module mf3_median_out #(
	parameter int PIXEL_BITS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             load,
	input  mf3_pkg::mf3_ctl_t                ctl,
	input  logic [2:0][2:0][PIXEL_BITS-1:0]  win,
	output logic                             done,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [mf3_pkg::DATA_W-1:0]       m_tdata,
	output logic [mf3_pkg::USER_W-1:0]       m_tuser,
	output logic                             m_tlast
);

	import mf3_pkg::*;

	localparam int PB = PIXEL_BITS;

	// returns {max, min}
	function automatic logic [2*PB-1:0] cx(input logic [PB-1:0] a, input logic [PB-1:0] b);
		return (a > b) ? {a, b} : {b, a};
	endfunction

	// 19 compare-exchange median network
	function automatic logic [PB-1:0] median9(input logic [2:0][2:0][PB-1:0] w);
		logic [PB-1:0] p [9];
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				p[3*i+j] = w[i][j];
			end
		end
		{p[2], p[1]} = cx(p[1], p[2]);
		{p[5], p[4]} = cx(p[4], p[5]);
		{p[8], p[7]} = cx(p[7], p[8]);
		{p[1], p[0]} = cx(p[0], p[1]);
		{p[4], p[3]} = cx(p[3], p[4]);
		{p[7], p[6]} = cx(p[6], p[7]);
		{p[2], p[1]} = cx(p[1], p[2]);
		{p[5], p[4]} = cx(p[4], p[5]);
		{p[8], p[7]} = cx(p[7], p[8]);
		{p[3], p[0]} = cx(p[0], p[3]);
		{p[8], p[5]} = cx(p[5], p[8]);
		{p[7], p[4]} = cx(p[4], p[7]);
		{p[6], p[3]} = cx(p[3], p[6]);
		{p[4], p[1]} = cx(p[1], p[4]);
		{p[5], p[2]} = cx(p[2], p[5]);
		{p[7], p[4]} = cx(p[4], p[7]);
		{p[2], p[4]} = cx(p[4], p[2]);
		{p[4], p[6]} = cx(p[6], p[4]);
		{p[2], p[4]} = cx(p[4], p[2]);
		return p[4];
	endfunction

	logic                           a_q;      // centre result pending
	logic                           b_q;      // right-edge result pending
	logic                           drain_q;
	logic                           out_free;
	logic                           push;
	logic [2:0][2:0][PB-1:0]        edge_win;
	logic [2:0][2:0][PB-1:0]        cand;
	logic [PB-1:0]                  med;
	logic [PB+DATA_W-1:0]           med_ext;
	logic                           valid_q;
	logic [DATA_W-1:0]              data_q;
	logic [USER_W-1:0]              user_q;
	logic                           last_q;

	assign out_free = !valid_q || m_tready;
	assign push     = (a_q || b_q) && out_free;
	assign done     = !(a_q || b_q) || (out_free && !(a_q && b_q));

	// right column replicated past the last pixel
	assign edge_win = {win[2], win[2], win[1]};
	assign cand     = a_q ? win : edge_win;
	assign med      = median9(cand);
	assign med_ext  = {{DATA_W{1'b0}}, med};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q     <= 1'b0;
			b_q     <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				a_q <= !ctl.col_zero && ctl.row_ge1;
				b_q <= ctl.last && ctl.row_ge1;
			end else if (push) begin
				if (a_q) begin
					a_q <= 1'b0;
				end else begin
					b_q <= 1'b0;
				end
			end
			if (push) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			drain_q <= ctl.drain;
		end
		if (push) begin
			data_q <= med_ext[DATA_W-1:0];
			if (a_q) begin
				user_q <= 2'b00;
				last_q <= !b_q;
			end else begin
				user_q <= {drain_q, 1'b1};
				last_q <= 1'b1;
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = user_q;
	assign m_tlast  = last_q;

endmodule

// ===== src/median_filter_3x3_replicate.sv =====
// 3x3 median filter over a raster-order grey pixel stream, edges replicated on all four
// sides. Set image_width/image_height while idle (0 acts as 1, width above MAX_WIDTH acts as
// MAX_WIDTH). The first row of a frame gives no results; each later input beat but the first
// of a row gives the result for the pixel one row up and one column left, and the last beat of
// a row also gives the right-edge result (row_end set). After the frame send one row
// (image_width beats) of drain beats to get the bottom output row; the last of those results
// carries frame_end. Input beats go in at one per clock while the result stage is free; a beat
// that gives two results holds the result stage until both are sent, as m_tready low does, so
// with m_tready high only the last beat of a result row stalls the input, and only when
// image_width is two or more. A result reaches m_tvalid through the registered line store read,
// the window register and the output register behind the nine-input compare network.
// No clearing pass after reset.
module median_filter_3x3_replicate #(
	parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [0:0]                    cfg_addr,
	input  logic [mf3_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [mf3_pkg::DATA_W-1:0]    s_tdata,   // [7:0] pixel_in
	input  logic                          s_tuser,   // flush (not read; the role follows the row count)
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [mf3_pkg::DATA_W-1:0]    m_tdata,   // [7:0] median_out
	output logic [mf3_pkg::USER_W-1:0]    m_tuser,   // [0] row_end, [1] frame_end
	output logic                          m_tlast    // last_of_run
);

	import mf3_pkg::*;

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int CMPW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
	localparam int PB   = PIXEL_BITS;
	localparam logic [CMPW-1:0] MAXW = CMPW'(MAX_WIDTH);

	logic [CFG_W-1:0]           width_q;
	logic [CFG_W-1:0]           height_q;
	logic [CW-1:0]              col_q;
	logic [CFG_W-1:0]           row_q;

	logic                       accept;
	logic                       en1;
	logic                       done;
	logic [CMPW-1:0]            w_ext;
	logic [CMPW-1:0]            w_eff;
	logic [CMPW-1:0]            col_ext;
	logic [CMPW-1:0]            c_ext;
	logic [CMPW-1:0]            c_inc;
	logic [CW-1:0]              c;
	logic [CFG_W-1:0]           h_eff;
	logic                       drain;
	logic                       last;
	logic [PB+DATA_W-1:0]       pix_ext;
	mf3_ctl_t                   ctl;

	logic                       s1_valid;
	logic [PB-1:0]              pix_s1;
	logic [CW-1:0]              c_s1;
	mf3_ctl_t                   ctl_s1;

	logic [2*PB-1:0]            rdata;
	logic [2:0][2:0][PB-1:0]    win;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (mf3_reg_t'(cfg_addr))
				REG_IMAGE_WIDTH:  width_q  <= cfg_wdata;
				REG_IMAGE_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// position of the incoming beat
	always_comb begin
		w_ext   = CMPW'(width_q);
		w_eff   = (w_ext == '0) ? CMPW'(1) : ((w_ext > MAXW) ? MAXW : w_ext);
		col_ext = CMPW'(col_q);
		c_ext   = (col_ext >= w_eff) ? (w_eff - CMPW'(1)) : col_ext;
		c_inc   = c_ext + CMPW'(1);
		c       = c_ext[CW-1:0];
		last    = (c_inc >= w_eff);
		h_eff   = (height_q == '0) ? CFG_W'(1) : height_q;
		drain   = (row_q >= h_eff);
		pix_ext = {{PB{1'b0}}, s_tdata};

		ctl.drain    = drain;
		ctl.last     = last;
		ctl.row_ge1  = (row_q != '0);
		ctl.row_le1  = (row_q <= CFG_W'(1));
		ctl.col_zero = (c == '0);
	end

	assign en1      = s1_valid && done;
	assign s_tready = !s1_valid || en1;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			s1_valid <= 1'b0;
		end else begin
			if (accept) begin
				if (last) begin
					col_q <= '0;
					row_q <= drain ? '0 : (row_q + CFG_W'(1));
				end else begin
					col_q <= c_inc[CW-1:0];
				end
				s1_valid <= 1'b1;
			end else if (en1) begin
				s1_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= pix_ext[PB-1:0];
			c_s1   <= c;
			ctl_s1 <= ctl;
		end
	end

	// {upper, middle} rows per column; upper takes the old middle on write
	mf3_line_buf #(
		.DEPTH (MAX_WIDTH),
		.DW    (2 * PB)
	) u_line_buf (
		.clk   (clk),
		.we    (en1 && !ctl_s1.drain),
		.waddr (c_s1),
		.wdata ({rdata[PB-1:0], pix_s1}),
		.re    (accept),
		.raddr (c),
		.rdata (rdata)
	);

	mf3_window #(
		.PIXEL_BITS (PB)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en1),
		.ctl      (ctl_s1),
		.pix      (pix_s1),
		.rd_upper (rdata[2*PB-1:PB]),
		.rd_mid   (rdata[PB-1:0]),
		.win      (win)
	);

	mf3_median_out #(
		.PIXEL_BITS (PB)
	) u_median_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (en1),
		.ctl      (ctl_s1),
		.win      (win),
		.done     (done),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tuser[0])
		else $error("frame_end without row_end");

	a_row_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast)
		else $error("row_end result not last of its beat");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		CMPW'(col_q) < MAXW)
		else $error("column count past line store depth");

	a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> s1_valid && !done)
		else $error("input stalled with pipe free");

endmodule
